@@ hdl/binary_erosion_cross3x3_unit_macros.svh @@
// Assertion helpers shared by the erosion unit.
`ifndef BINARY_EROSION_CROSS3X3_UNIT_MACROS_SVH
`define BINARY_EROSION_CROSS3X3_UNIT_MACROS_SVH

// Same-cycle implication.
`define BEC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BEC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/bec_pkg.sv @@
package bec_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int WID_W       = COL_W + 1;
   localparam int ROW_W       = 12;
   localparam int CFG_WIDTH_W = 11;
   localparam int PIX_W       = 8;
   localparam int MAX_RESULTS = 3;
   localparam int RES_CNT_W   = 2;
   localparam int QDEPTH      = 4;
   localparam int QCNT_W      = $clog2(QDEPTH + 1);

   localparam logic [CFG_WIDTH_W-1:0] WIDTH_RESET  = 11'd480;
   localparam logic [ROW_W-1:0]       HEIGHT_RESET = 12'd270;

   localparam logic [PIX_W-1:0] FG_VALUE = 8'd255;
   localparam logic [PIX_W-1:0] BG_VALUE = 8'd0;

   // register index, taken from paddr[2]
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      FILL_BACK,
      FILL_FWD,
      FILL_DONE
   } fill_state_type;

   typedef struct packed {
      logic older;
      logic newer;
   } row_word_type;

   typedef struct packed {
      logic             rd_en;
      logic [COL_W-1:0] rd_addr0;
      logic [COL_W-1:0] rd_addr1;
      logic             wr_en;
      logic [COL_W-1:0] wr_addr;
      row_word_type     wr_data;
   } mem_req_type;

   typedef struct packed {
      logic [PIX_W-1:0] eroded_value;
      logic             frame_end;
      logic             run_end;
   } result_type;

   typedef struct packed {
      logic [RES_CNT_W-1:0]              count;
      result_type [MAX_RESULTS-1:0]      item;
   } push_type;

   typedef struct packed {
      logic              space;
      logic [QCNT_W-1:0] count;
   } queue_stat_type;

endpackage

@@ hdl/bec_rowmem.sv @@
module bec_rowmem (
   input  logic                  clock,
   input  bec_pkg::mem_req_type  req,
   output bec_pkg::row_word_type rd0,
   output bec_pkg::row_word_type rd1
);
   import bec_pkg::*;

   row_word_type mem_ff [MAX_WIDTH];
   row_word_type rd0_ff;
   row_word_type rd1_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem_ff[req.wr_addr] <= req.wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd0_ff <= mem_ff[req.rd_addr0];
         rd1_ff <= mem_ff[req.rd_addr1];
      end
   end

   assign rd0 = rd0_ff;
   assign rd1 = rd1_ff;

endmodule

@@ hdl/bec_outq.sv @@
module bec_outq (
   input  logic                                clock,
   input  logic                                reset,
   input  bec_pkg::push_type                   push,
   output bec_pkg::queue_stat_type             stat,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [bec_pkg::PIX_W-1:0]           rsp_eroded_value,
   output logic                                rsp_frame_end,
   output logic                                rsp_run_end
);
   import bec_pkg::*;

   result_type        slot_ff [QDEPTH];
   result_type        slot_in [QDEPTH];
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic [QCNT_W-1:0] base;
   logic              pop;

   always_comb begin
      pop  = (count_ff != '0) && !rsp_stall;
      base = count_ff - QCNT_W'(pop);
      for (int i = 0; i < QDEPTH - 1; i++) begin
         slot_in[i] = pop ? slot_ff[i+1] : slot_ff[i];
      end
      slot_in[QDEPTH-1] = slot_ff[QDEPTH-1];
      for (int i = 0; i < QDEPTH; i++) begin
         for (int j = 0; j < MAX_RESULTS; j++) begin
            if ((QCNT_W'(j) < QCNT_W'(push.count)) &&
                (base + QCNT_W'(j) == QCNT_W'(i))) begin
               slot_in[i] = push.item[j];
            end
         end
      end
      count_in = base + QCNT_W'(push.count);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QDEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   assign stat.space       = (count_ff <= QCNT_W'(QDEPTH - MAX_RESULTS));
   assign stat.count       = count_ff;
   assign rsp_valid        = (count_ff != '0);
   assign rsp_eroded_value = slot_ff[0].eroded_value;
   assign rsp_frame_end    = slot_ff[0].frame_end;
   assign rsp_run_end      = slot_ff[0].run_end;

endmodule

@@ hdl/bec_core.sv @@
module bec_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cfg_wr,
   input  logic [bec_pkg::WID_W-1:0]   w_eff,
   input  logic [bec_pkg::ROW_W-1:0]   h_eff,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [bec_pkg::PIX_W-1:0]   req_pixel_value,
   input  logic                        q_space,
   output bec_pkg::push_type           push,
   output bec_pkg::mem_req_type        mem_req,
   input  bec_pkg::row_word_type       mem_rd0,
   input  bec_pkg::row_word_type       mem_rd1
);
   import bec_pkg::*;

   fill_state_type   state_ff, state_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             prev_bit_ff, prev_bit_in;
   logic             prev2_ff, prev2_in;       // newer row, two columns back
   logic             left_new_ff, left_new_in; // newer row, one column back
   logic             upleft_ff, upleft_in;     // older row, one column back
   logic             fwd0_ff, fwd0_in;
   logic             fwd1_ff, fwd1_in;
   row_word_type     fwd_word_ff, fwd_word_in;

   logic [COL_W-1:0] c_cl, c_next, cn_p1, c_p1, c_m1, c_m2;
   logic [ROW_W-1:0] r_cl, r_next;
   logic             last_col, last_row, cur, accept;
   row_word_type     e0, wdata;
   logic             n1;
   logic             v1, v2, v3, ok1, ok2, ok3;
   logic [RES_CNT_W-1:0] idx;

   always_comb begin
      c_cl     = (WID_W'(col_ff) < w_eff) ? col_ff : COL_W'(w_eff - 1'b1);
      r_cl     = (row_ff < h_eff) ? row_ff : h_eff - 1'b1;
      last_col = (WID_W'(c_cl) == w_eff - 1'b1);
      last_row = (r_cl == h_eff - 1'b1);
      c_next   = last_col ? '0 : c_cl + 1'b1;
      r_next   = last_col ? (last_row ? '0 : r_cl + 1'b1) : r_cl;
      cn_p1    = c_next + 1'b1;
      c_p1     = c_cl + 1'b1;
      c_m1     = c_cl - 1'b1;
      c_m2     = c_cl - 2'd2;
      cur      = (req_pixel_value != '0);
      // bypass the word written on the same edge as the read
      e0       = fwd0_ff ? fwd_word_ff : mem_rd0;
      n1       = fwd1_ff ? fwd_word_ff.newer : mem_rd1.newer;
      wdata.older = e0.newer;
      wdata.newer = cur;
   end

   assign req_stall = (state_ff != FILL_DONE) || !q_space || cfg_wr;
   assign accept    = req_valid && !req_stall;

   // results: row above, late pixel of the last row, frame flush
   always_comb begin
      v1  = (r_cl != '0);
      ok1 = e0.newer && cur && ((r_cl < ROW_W'(2)) || e0.older) &&
            ((c_cl == '0) || upleft_ff) && (last_col || n1);
      v2  = last_row && (c_cl != '0);
      ok2 = prev_bit_ff && cur && ((r_cl == '0) || upleft_ff) &&
            ((c_cl < COL_W'(2)) || prev2_ff);
      v3  = last_row && last_col;
      ok3 = cur && ((r_cl == '0) || e0.newer) && ((c_cl == '0) || left_new_ff);

      push = '0;
      idx  = '0;
      if (v1) begin
         push.item[idx].eroded_value = ok1 ? FG_VALUE : BG_VALUE;
         push.item[idx].run_end      = !v2 && !v3;
         idx = idx + 1'b1;
      end
      if (v2) begin
         push.item[idx].eroded_value = ok2 ? FG_VALUE : BG_VALUE;
         push.item[idx].run_end      = !v3;
         idx = idx + 1'b1;
      end
      if (v3) begin
         push.item[idx].eroded_value = ok3 ? FG_VALUE : BG_VALUE;
         push.item[idx].frame_end    = 1'b1;
         push.item[idx].run_end      = 1'b1;
         idx = idx + 1'b1;
      end
      push.count = accept ? idx : '0;
   end

   always_comb begin
      mem_req     = '0;
      state_in    = state_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      prev_bit_in = prev_bit_ff;
      prev2_in    = prev2_ff;
      left_new_in = left_new_ff;
      upleft_in   = upleft_ff;
      fwd0_in     = fwd0_ff;
      fwd1_in     = fwd1_ff;
      fwd_word_in = fwd_word_ff;
      unique case (state_ff)
         FILL_BACK: begin
            mem_req.rd_en    = 1'b1;
            mem_req.rd_addr0 = c_m1;
            mem_req.rd_addr1 = c_m2;
            fwd0_in          = 1'b0;
            fwd1_in          = 1'b0;
            state_in         = FILL_FWD;
         end
         FILL_FWD: begin
            upleft_in        = e0.older;
            left_new_in      = e0.newer;
            prev2_in         = n1;
            mem_req.rd_en    = 1'b1;
            mem_req.rd_addr0 = c_cl;
            mem_req.rd_addr1 = c_p1;
            fwd0_in          = 1'b0;
            fwd1_in          = 1'b0;
            state_in         = FILL_DONE;
         end
         FILL_DONE: begin
            if (accept) begin
               mem_req.rd_en    = 1'b1;
               mem_req.rd_addr0 = c_next;
               mem_req.rd_addr1 = cn_p1;
               mem_req.wr_en    = 1'b1;
               mem_req.wr_addr  = c_cl;
               mem_req.wr_data  = wdata;
               fwd0_in          = (c_next == c_cl);
               fwd1_in          = (cn_p1 == c_cl);
               fwd_word_in      = wdata;
               upleft_in        = e0.newer;
               left_new_in      = cur;
               prev2_in         = left_new_ff;
               prev_bit_in      = cur;
               col_in           = c_next;
               row_in           = r_next;
            end
         end
         default: begin
            state_in = FILL_BACK;
         end
      endcase
      // counters may now lie outside the frame: fetch the window again
      if (cfg_wr) begin
         state_in = FILL_BACK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= FILL_BACK;
         col_ff      <= '0;
         row_ff      <= '0;
         prev_bit_ff <= 1'b0;
         fwd0_ff     <= 1'b0;
         fwd1_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         prev_bit_ff <= prev_bit_in;
         fwd0_ff     <= fwd0_in;
         fwd1_ff     <= fwd1_in;
      end
   end

   always_ff @(posedge clock) begin
      prev2_ff    <= prev2_in;
      left_new_ff <= left_new_in;
      upleft_ff   <= upleft_in;
      fwd_word_ff <= fwd_word_in;
   end

endmodule

@@ hdl/binary_erosion_cross3x3_unit.sv @@
// Streaming binary erosion with a plus-shaped 3x3 element.
// req_ channel: one pixel per item in raster order, nonzero is foreground.
// rsp_ channel: eroded pixels (255 or 0) in raster order, one row behind the
// input; on the last row each item also yields the pixel to its left, and
// the frame's final item flushes the last pixel with rsp_frame_end set.
// rsp_run_end marks the last result caused by an input item.
// A result is registered into the output queue when its item is taken.
// Throughput: one item per cycle while rsp_stall is low and each item yields
// at most one result; last-row items yield more and are held off by the
// one-result-per-cycle output queue. Row stores are a 2-bit-wide memory with
// two read ports; the next column's window is read ahead as each item is taken.
// req_stall is high while FILL_BACK and FILL_FWD fetch the window after reset
// and after a register write, which also stalls. The row stores are not cleared.
// req_stall is high while more than one result waits in the four-deep queue,
// so a stalled receiver holds off the input; nothing is dropped.
// Registers: image_width at 0x0 (11 bits), image_height at 0x4 (12 bits).
`include "binary_erosion_cross3x3_unit_macros.svh"

module binary_erosion_cross3x3_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [bec_pkg::PIX_W-1:0]     req_pixel_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bec_pkg::PIX_W-1:0]     rsp_eroded_value,
   output logic                          rsp_frame_end,
   output logic                          rsp_run_end,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [2:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import bec_pkg::*;

   logic [CFG_WIDTH_W-1:0] width_ff, width_in;
   logic [ROW_W-1:0]       height_ff, height_in;
   logic [WID_W-1:0]       w_eff;
   logic [ROW_W-1:0]       h_eff;
   logic                   cfg_wr;
   push_type               push;
   queue_stat_type         q_stat;
   mem_req_type            mem_req;
   row_word_type           mem_rd0;
   row_word_type           mem_rd1;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (cfg_wr) begin
         unique case (paddr[2])
            REG_WIDTH:  width_in  = pwdata[CFG_WIDTH_W-1:0];
            REG_HEIGHT: height_in = pwdata[ROW_W-1:0];
            default:    width_in  = width_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_WIDTH:  prdata = 32'(width_ff);
         REG_HEIGHT: prdata = 32'(height_ff);
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // zero counts as one, widths above the store depth saturate
   always_comb begin
      if (width_ff == '0) begin
         w_eff = WID_W'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WID_W'(MAX_WIDTH);
      end else begin
         w_eff = WID_W'(width_ff);
      end
      h_eff = (height_ff == '0) ? ROW_W'(1) : height_ff;
   end

   bec_core u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg_wr          (cfg_wr),
      .w_eff           (w_eff),
      .h_eff           (h_eff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_value (req_pixel_value),
      .q_space         (q_stat.space),
      .push            (push),
      .mem_req         (mem_req),
      .mem_rd0         (mem_rd0),
      .mem_rd1         (mem_rd1)
   );

   bec_rowmem u_rowmem (
      .clock (clock),
      .req   (mem_req),
      .rd0   (mem_rd0),
      .rd1   (mem_rd1)
   );

   bec_outq u_outq (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .stat             (q_stat),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_eroded_value (rsp_eroded_value),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_run_end      (rsp_run_end)
   );

   `BEC_ASSERT_SAME(a_frame_end_closes_run, clock, reset, rsp_valid && rsp_frame_end, rsp_run_end, "frame end without run end")
   `BEC_ASSERT_NEXT(a_cfg_refetch, clock, reset, cfg_wr, req_stall, "item taken before window refetch")
   `BEC_ASSERT_SAME(a_queue_bound, clock, reset, 1'b1, q_stat.count <= QCNT_W'(QDEPTH), "result queue overflow")

endmodule
